>>> hw/rtl/trsd_pkg.sv
// Package for the tracker record sync/decode block: widths, sync constants,
// the queue entry type and the coordinate helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package trsd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned RecLen     = 8;
  localparam int unsigned HeldBytes  = RecLen - 1;
  localparam int unsigned CntW       = $clog2(RecLen);
  localparam int unsigned RawW       = 16;
  localparam int unsigned CoordW     = 21;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned ShiftW     = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QIdxW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [3:0] SyncMark   = 4'h8;
  localparam logic [7:0] TargetMask = 8'h0c;

  typedef enum logic [1:0] {
    ST_SYNC   = 2'b01,
    ST_GATHER = 2'b10
  } front_state_e;

  typedef struct packed {
    logic [RawW-1:0]    x_raw;
    logic [RawW-1:0]    y_raw;
    logic [RawW-1:0]    z_raw;
    logic [StatusW-1:0] status;
    logic [ShiftW-1:0]  shift;
  } rec_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } queue_status_t;

  function automatic logic is_mark(input logic [ByteW-1:0] b);
    return b[ByteW-1 -: 4] == SyncMark;
  endfunction

  function automatic logic signed [CoordW-1:0] coord_shift(input logic [RawW-1:0] raw,
                                                           input logic [ShiftW-1:0] sh);
    logic signed [CoordW-1:0] ext;
    ext = {{(CoordW - RawW){raw[RawW-1]}}, raw};
    return ext <<< sh;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/trsd_front.sv
// Front end: byte sync, record gathering and record checks.
// Depends on trsd_pkg; pushes checked records into trsd_queue.
`timescale 1ns / 1ps
`default_nettype none
module trsd_front import trsd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output rec_t                  push_data_o
);

  front_state_e         state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [ByteW-1:0]     bytes_q [HeldBytes];
  logic                 accept;
  logic                 rec_ok;
  logic                 last_byte;
  logic [StatusW-1:0]   status;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign last_byte  = (state_q == ST_GATHER) && (count_q == CntW'(HeldBytes));
  assign status     = bytes_q[1][StatusW-1:0];

  always_comb begin
    rec_ok = is_mark(bytes_q[0]) && is_mark(bytes_q[1]);
    if (is_mark(bytes_q[2]) && is_mark(bytes_q[3])) rec_ok = 1'b0;
    if (is_mark(bytes_q[4]) && is_mark(bytes_q[5])) rec_ok = 1'b0;
    if (is_mark(bytes_q[6]) && is_mark(rx_byte_i)) rec_ok = 1'b0;
    if (status[1] && ((bytes_q[0] & TargetMask) != '0)) rec_ok = 1'b0;
  end

  assign push_o             = accept && last_byte && rec_ok;
  assign push_data_o.x_raw  = {bytes_q[2], bytes_q[3]};
  assign push_data_o.y_raw  = {bytes_q[4], bytes_q[5]};
  assign push_data_o.z_raw  = {bytes_q[6], rx_byte_i};
  assign push_data_o.status = status;
  assign push_data_o.shift  = {bytes_q[0][1], 1'b0, bytes_q[0][0]};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    if (accept) begin
      unique case (state_q)
        ST_SYNC: begin
          if (is_mark(rx_byte_i)) begin
            state_d = ST_GATHER;
            count_d = CntW'(1);
          end
        end
        ST_GATHER: begin
          if (last_byte) begin
            state_d = ST_SYNC;
            count_d = '0;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        default: begin
          state_d = ST_SYNC;
          count_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !last_byte) begin
      if (state_q == ST_SYNC) begin
        bytes_q[0] <= rx_byte_i;
      end else begin
        bytes_q[count_q] <= rx_byte_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/trsd_queue.sv
// Short record queue between the front end and the back end.
// Depends on trsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trsd_queue import trsd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire rec_t  push_data_i,
  input  wire logic  pop_i,
  output rec_t       pop_data_o,
  output queue_status_t status_o
);

  rec_t             mem_q [QueueDepth];
  logic [QIdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign status_o.full  = (count_q == QCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QIdxW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QIdxW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QIdxW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QIdxW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/trsd_back.sv
// Back end: applies the exponent shift and holds the output transaction.
// Depends on trsd_pkg; pops records from trsd_queue.
`timescale 1ns / 1ps
`default_nettype none
module trsd_back import trsd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire rec_t                 pop_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [CoordW-1:0]  x_pos_o,
  output logic signed [CoordW-1:0]  y_pos_o,
  output logic signed [CoordW-1:0]  z_pos_o,
  output logic [StatusW-1:0]        track_status_o,
  output logic [ShiftW-1:0]         scale_shift_o
);

  logic                     valid_q;
  logic signed [CoordW-1:0] x_q, y_q, z_q;
  logic [StatusW-1:0]       status_q;
  logic [ShiftW-1:0]        shift_q;

  assign pop_o = !q_empty_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q      <= coord_shift(pop_data_i.x_raw, pop_data_i.shift);
      y_q      <= coord_shift(pop_data_i.y_raw, pop_data_i.shift);
      z_q      <= coord_shift(pop_data_i.z_raw, pop_data_i.shift);
      status_q <= pop_data_i.status;
      shift_q  <= pop_data_i.shift;
    end
  end

  assign out_valid_o    = valid_q;
  assign x_pos_o        = x_q;
  assign y_pos_o        = y_q;
  assign z_pos_o        = z_q;
  assign track_status_o = status_q;
  assign scale_shift_o  = shift_q;

endmodule
`default_nettype wire

>>> hw/rtl/tracker_record_sync_decode.sv
// Tracker record sync/decode, top level.
// Depends on trsd_pkg, trsd_front, trsd_queue and trsd_back.
//
// Input channel: one received serial byte per transaction (rx_byte_i), taken
// when in_valid_i is high and in_stall_o is low. Bytes are dropped until one
// with high nibble 0x8 arrives; that byte and the next seven form a record.
// Output channel: one transaction per valid record carrying x/y/z positions
// (sign-extended and shifted left by the exponent code), the tracking status
// and the shift used. Taken when out_valid_o is high and out_stall_i is low.
// Bad records are dropped silently and the parser resyncs on the next byte.
// Throughput: one byte per cycle while in_stall_o is low. A checked record is
// pushed into the queue at the clock edge that takes its eighth byte.
// Checked records pass through a two-entry queue into a back-end output
// register. When the receiver stalls, the output holds and records pile up
// in the queue; once the queue is full, in_stall_o goes high.
// Reset (rst_ni low, asynchronous) returns the parser to syncing, empties
// the queue and clears out_valid_o.
`timescale 1ns / 1ps
`default_nettype none
module tracker_record_sync_decode import trsd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ByteW-1:0]    rx_byte_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [CoordW-1:0] x_pos_o,
  output logic signed [CoordW-1:0] y_pos_o,
  output logic signed [CoordW-1:0] z_pos_o,
  output logic [StatusW-1:0]       track_status_o,
  output logic [ShiftW-1:0]        scale_shift_o
);

  logic          push, pop;
  rec_t          push_data, pop_data;
  queue_status_t q_status;

  trsd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .q_full_i    (q_status.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  trsd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  trsd_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i  (q_status.empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o,
    .out_stall_i,
    .x_pos_o,
    .y_pos_o,
    .z_pos_o,
    .track_status_o,
    .scale_shift_o
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("record pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("record popped from an empty queue");

  a_out_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop))
    else $error("output became valid without a queue pop");

endmodule
`default_nettype wire

>>> dv/tracker_record_sync_decode_tb.sv
// Testbench for tracker_record_sync_decode: a directed table of bytes, then random
// records, broken records and noise, with random gaps and stalls on both channels.
// Results are checked against an in-bench record parser. Depends on trsd_pkg.
`timescale 1ns / 1ps
module tracker_record_sync_decode_tb;
  import trsd_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [StatusW-1:0]       status;
    logic [ShiftW-1:0]        shift;
  } pos_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             typed;
    pos_t             exp;
  } dir_row_t;

  typedef enum int {
    REC_GOOD,
    REC_BAD_HEAD,
    REC_BAD_TARGET,
    REC_BAD_PAIR,
    REC_CUT
  } rec_kind_e;

  localparam int          DirRows      = 25;
  localparam int          RandRecBytes = 1950;
  localparam int          MaxWait      = 18;
  localparam logic [1:0]  TargetStatus = 2'd2;
  localparam pos_t        NoRec        = '0;
  localparam pos_t        ExtremeRec   = '{21'h0fffe0, 21'h100000, 21'h000000, 2'd3, 3'd5};

  // junk byte, full-scale record, record rejected on target bits, record with shift 4
  localparam dir_row_t DirTab [DirRows] = '{
    '{8'h00, 1'b0, NoRec},
    '{8'h83, 1'b0, NoRec}, '{8'h83, 1'b0, NoRec}, '{8'h7f, 1'b0, NoRec},
    '{8'hff, 1'b0, NoRec}, '{8'h80, 1'b0, NoRec}, '{8'h00, 1'b0, NoRec},
    '{8'h00, 1'b0, NoRec}, '{8'h00, 1'b1, ExtremeRec},
    '{8'h8c, 1'b0, NoRec}, '{8'h82, 1'b0, NoRec}, '{8'hff, 1'b0, NoRec},
    '{8'hff, 1'b0, NoRec}, '{8'h01, 1'b0, NoRec}, '{8'h23, 1'b0, NoRec},
    '{8'h45, 1'b0, NoRec}, '{8'h67, 1'b0, NoRec},
    '{8'h8e, 1'b0, NoRec}, '{8'h81, 1'b0, NoRec}, '{8'hff, 1'b0, NoRec},
    '{8'hff, 1'b0, NoRec}, '{8'h12, 1'b0, NoRec}, '{8'h34, 1'b0, NoRec},
    '{8'h80, 1'b0, NoRec}, '{8'h7f, 1'b0, NoRec}
  };

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic [ByteW-1:0]         rx_byte_i   = '0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [CoordW-1:0] x_pos_o;
  logic signed [CoordW-1:0] y_pos_o;
  logic signed [CoordW-1:0] z_pos_o;
  logic [StatusW-1:0]       track_status_o;
  logic [ShiftW-1:0]        scale_shift_o;

  pos_t              pos_expect_q [$];
  logic [ByteW-1:0]  rec_held [HeldBytes];
  logic [CntW-1:0]   held_cnt  = '0;
  bit                gathering = 1'b0;
  int                mismatches = 0;
  int                rec_bytes_sent = 0;
  int                rx_wait = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;

  tracker_record_sync_decode dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .x_pos_o        (x_pos_o),
    .y_pos_o        (y_pos_o),
    .z_pos_o        (z_pos_o),
    .track_status_o (track_status_o),
    .scale_shift_o  (scale_shift_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit is_sync(input logic [ByteW-1:0] b);
    return b[ByteW-1 -: 4] == SyncMark;
  endfunction

  function automatic logic signed [CoordW-1:0] scaled_coord(input logic [RawW-1:0] raw,
                                                            input logic [ShiftW-1:0] sh);
    logic signed [CoordW-1:0] ext;
    ext = {{(CoordW - RawW){raw[RawW-1]}}, raw};
    return ext <<< sh;
  endfunction

  // Advances the parser by one byte; returns 1 when a good record completes.
  function automatic bit track_parse(input logic [ByteW-1:0] b, output pos_t rec);
    logic [ByteW-1:0]    r [RecLen];
    logic [StatusW-1:0]  st;
    logic [ShiftW-1:0]   sh;
    bit                  ok;
    int                  i;
    rec = '0;
    if (!gathering) begin
      if (is_sync(b)) begin
        rec_held[0] = b;
        held_cnt    = CntW'(1);
        gathering   = 1'b1;
      end
      return 1'b0;
    end
    if (held_cnt < HeldBytes) begin
      rec_held[held_cnt] = b;
      held_cnt           = held_cnt + 1'b1;
      return 1'b0;
    end
    for (i = 0; i < HeldBytes; i++) r[i] = rec_held[i];
    r[RecLen-1] = b;
    gathering   = 1'b0;
    held_cnt    = '0;
    ok = is_sync(r[0]) && is_sync(r[1]);
    for (i = 2; i < RecLen; i += 2)
      if (is_sync(r[i]) && is_sync(r[i+1])) ok = 1'b0;
    st = r[1][StatusW-1:0];
    if (st >= TargetStatus && (r[0] & TargetMask) != '0) ok = 1'b0;
    if (!ok) return 1'b0;
    sh         = {r[0][1], 1'b0, r[0][0]};
    rec.x      = scaled_coord({r[2], r[3]}, sh);
    rec.y      = scaled_coord({r[4], r[5]}, sh);
    rec.z      = scaled_coord({r[6], r[7]}, sh);
    rec.status = st;
    rec.shift  = sh;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input pos_t typed_rec);
    int   gap;
    pos_t rec;
    bit   hit;
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    rec_bytes_sent++;
    hit = track_parse(b, rec);
    if (typed) pos_expect_q.push_back(typed_rec);
    else if (hit) pos_expect_q.push_back(rec);
  endtask

  task automatic send_record(input rec_kind_e kind);
    logic [ByteW-1:0] rb [RecLen];
    int               k;
    int               n;
    rb[0] = {SyncMark, 4'($urandom)};
    rb[1] = {SyncMark, 4'($urandom)};
    if (rb[1][1]) rb[0][3:2] = 2'b00;
    for (k = 2; k < RecLen; k += 2) begin
      case ($urandom_range(0, 5))
        0:       rb[k] = 8'h7f;
        1:       rb[k] = 8'h80;
        2:       rb[k] = 8'hff;
        3:       rb[k] = 8'h00;
        default: rb[k] = 8'($urandom);
      endcase
      rb[k+1] = 8'($urandom);
      if ($urandom_range(0, 3) == 0) rb[k+1] = rb[k][7] ? 8'h00 : 8'hff;
      if (is_sync(rb[k]) && is_sync(rb[k+1])) rb[k+1] ^= 8'h40;
    end
    n = RecLen;
    case (kind)
      REC_BAD_HEAD: begin
        rb[1] = 8'($urandom);
        if (is_sync(rb[1])) rb[1] ^= 8'h10;
      end
      REC_BAD_TARGET: begin
        rb[1][1]   = 1'b1;
        rb[0][3:2] = 2'($urandom_range(1, 3));
      end
      REC_BAD_PAIR: begin
        k       = 2 * $urandom_range(1, 3);
        rb[k]   = {SyncMark, 4'($urandom)};
        rb[k+1] = {SyncMark, 4'($urandom)};
      end
      REC_CUT: n = $urandom_range(1, RecLen - 1);
      default: ;
    endcase
    for (k = 0; k < n; k++) send_byte(rb[k], 1'b0, NoRec);
  endtask

  task automatic field_check(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : rx_side
    pos_t want;
    int   nxt;
    if (rst_ni) begin
      nxt = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        if (pos_expect_q.size() == 0) begin
          $display("%0t: unexpected transaction x %0d y %0d z %0d", $time,
                   x_pos_o, y_pos_o, z_pos_o);
          mismatches++;
        end else begin
          want = pos_expect_q.pop_front();
          field_check("x_pos", want.x, x_pos_o);
          field_check("y_pos", want.y, y_pos_o);
          field_check("z_pos", want.z, z_pos_o);
          field_check("track_status", want.status, track_status_o);
          field_check("scale_shift", want.shift, scale_shift_o);
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        nxt = rx_calm ? 0 : $urandom_range(0, MaxWait);
      end else if (nxt != 0) begin
        nxt--;
      end
      rx_wait = nxt;
      out_stall_i <= (nxt != 0);
    end
  end

  initial begin
    int draw;
    int i;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < DirRows; i++) send_byte(DirTab[i].b, DirTab[i].typed, DirTab[i].exp);
    while (rec_bytes_sent < RandRecBytes) begin
      draw = $urandom_range(0, 9);
      if (draw < 6) send_record(REC_GOOD);
      else if (draw < 8) send_record(rec_kind_e'($urandom_range(int'(REC_BAD_HEAD), int'(REC_CUT))));
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, NoRec);
    end
    in_valid_i <= 1'b0;
    while (pos_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
